[rtl/core/imu_nine_axis_running_median_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nine-axis running median filter
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef IMU_NINE_AXIS_RUNNING_MEDIAN_TOP_MACROS_SVH
`define IMU_NINE_AXIS_RUNNING_MEDIAN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMU9RM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMU9RM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/imu9rm_pkg.sv]
// ----------------------------------------------------------------------------
// imu9rm_pkg
// Shared types and constants of the nine-axis running median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imu9rm_pkg;

    // Number of sensor channels in one sample beat.
    localparam int CHANNELS = 9;

    // Comparison flags that one sort cell hands to its neighbors.
    typedef struct packed {
        logic gt;      // the stored value is greater than the new sample
        logic del_le;  // the oldest entry sits in this cell or below it
    } cell_flags_t;

endpackage

`default_nettype wire

[rtl/core/imu9rm_sample_if.sv]
// ----------------------------------------------------------------------------
// imu9rm_sample_if
// Valid/ready channel that carries one nine-axis raw sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface imu9rm_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
    logic signed [SAMPLE_BITS-1:0] mag_x;
    logic signed [SAMPLE_BITS-1:0] mag_y;
    logic signed [SAMPLE_BITS-1:0] mag_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               mag_x, mag_y, mag_z,
        input  ready
    );

    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               mag_x, mag_y, mag_z,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/imu9rm_median_if.sv]
// ----------------------------------------------------------------------------
// imu9rm_median_if
// Valid/ready channel that carries the nine windowed medians per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface imu9rm_median_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median_accel_x;
    logic signed [SAMPLE_BITS-1:0] median_accel_y;
    logic signed [SAMPLE_BITS-1:0] median_accel_z;
    logic signed [SAMPLE_BITS-1:0] median_gyro_x;
    logic signed [SAMPLE_BITS-1:0] median_gyro_y;
    logic signed [SAMPLE_BITS-1:0] median_gyro_z;
    logic signed [SAMPLE_BITS-1:0] median_mag_x;
    logic signed [SAMPLE_BITS-1:0] median_mag_y;
    logic signed [SAMPLE_BITS-1:0] median_mag_z;

    modport source (
        output valid, median_accel_x, median_accel_y, median_accel_z,
               median_gyro_x, median_gyro_y, median_gyro_z,
               median_mag_x, median_mag_y, median_mag_z,
        input  ready
    );

    modport sink (
        input  valid, median_accel_x, median_accel_y, median_accel_z,
               median_gyro_x, median_gyro_y, median_gyro_z,
               median_mag_x, median_mag_y, median_mag_z,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/imu9rm_cell.sv]
// ----------------------------------------------------------------------------
// imu9rm_cell
// One slot of a sorted window: holds a value and its age, and on each new
// sample takes its next entry from itself, a neighbor or the new sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu9rm_cell
    import imu9rm_pkg::*;
#(
    parameter int WINDOW      = 4,
    parameter int SAMPLE_BITS = 16,
    parameter int RESET_AGE   = 0,
    localparam int AGE_W      = $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic signed [SAMPLE_BITS-1:0] lower_value,
    input  wire logic        [AGE_W-1:0]       lower_age,
    input  wire cell_flags_t                   lower_flags,
    input  wire logic signed [SAMPLE_BITS-1:0] upper_value,
    input  wire logic        [AGE_W-1:0]       upper_age,
    input  wire cell_flags_t                   upper_flags,
    output logic signed      [SAMPLE_BITS-1:0] value,
    output logic             [AGE_W-1:0]       age,
    output cell_flags_t                        flags,
    output logic signed      [SAMPLE_BITS-1:0] value_next
);

    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WINDOW - 1);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic        [AGE_W-1:0]       age_reg;
    logic        [AGE_W-1:0]       age_next;
    logic                          keep_low;
    logic                          take_high;

    assign flags.gt     = value_reg > sample;
    assign flags.del_le = lower_flags.del_le | (age_reg == OLDEST);

    // With the oldest entry removed, the remaining list is shifted down past
    // the removed slot. The new sample lands where that list crosses it.
    always_comb
    begin
        keep_low  = flags.del_le ? !upper_flags.gt : !flags.gt;
        take_high = lower_flags.del_le ? flags.gt : lower_flags.gt;
        if (keep_low)
        begin
            value_next = flags.del_le ? upper_value : value_reg;
            age_next   = AGE_W'((flags.del_le ? upper_age : age_reg) + 1'b1);
        end
        else if (take_high)
        begin
            value_next = lower_flags.del_le ? value_reg : lower_value;
            age_next   = AGE_W'((lower_flags.del_le ? age_reg : lower_age) + 1'b1);
        end
        else
        begin
            value_next = sample;
            age_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= AGE_W'(RESET_AGE);
        end
        else if (shift)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

`default_nettype wire

[rtl/core/imu9rm_lane.sv]
// ----------------------------------------------------------------------------
// imu9rm_lane
// One sensor channel: a row of sort cells and the median pick-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu9rm_lane
    import imu9rm_pkg::*;
#(
    parameter int WINDOW      = 4,
    parameter int SAMPLE_BITS = 16,
    localparam int AGE_W      = $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed      [SAMPLE_BITS-1:0] median_next
);

    logic signed [SAMPLE_BITS-1:0] cell_value      [WINDOW];
    logic        [AGE_W-1:0]       cell_age        [WINDOW];
    cell_flags_t                   cell_flags      [WINDOW];
    logic signed [SAMPLE_BITS-1:0] cell_value_next [WINDOW];

    // Boundary neighbors: below the first cell sits minus infinity with no
    // removed entry; above the last cell sits plus infinity.
    localparam cell_flags_t LOW_END  = '{gt: 1'b0, del_le: 1'b0};
    localparam cell_flags_t HIGH_END = '{gt: 1'b1, del_le: 1'b1};

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] lower_value;
            logic        [AGE_W-1:0]       lower_age;
            cell_flags_t                   lower_flags;
            logic signed [SAMPLE_BITS-1:0] upper_value;
            logic        [AGE_W-1:0]       upper_age;
            cell_flags_t                   upper_flags;

            if (i == 0)
            begin : g_low
                assign lower_value = '0;
                assign lower_age   = '0;
                assign lower_flags = LOW_END;
            end
            else
            begin : g_mid_low
                assign lower_value = cell_value[i-1];
                assign lower_age   = cell_age[i-1];
                assign lower_flags = cell_flags[i-1];
            end

            if (i == WINDOW - 1)
            begin : g_high
                assign upper_value = '0;
                assign upper_age   = '0;
                assign upper_flags = HIGH_END;
            end
            else
            begin : g_mid_high
                assign upper_value = cell_value[i+1];
                assign upper_age   = cell_age[i+1];
                assign upper_flags = cell_flags[i+1];
            end

            imu9rm_cell #(
                .WINDOW      (WINDOW),
                .SAMPLE_BITS (SAMPLE_BITS),
                .RESET_AGE   (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .sample      (sample),
                .lower_value (lower_value),
                .lower_age   (lower_age),
                .lower_flags (lower_flags),
                .upper_value (upper_value),
                .upper_age   (upper_age),
                .upper_flags (upper_flags),
                .value       (cell_value[i]),
                .age         (cell_age[i]),
                .flags       (cell_flags[i]),
                .value_next  (cell_value_next[i])
            );
        end

        if ((WINDOW % 2) == 0)
        begin : g_even
            // Mean of the two middle entries, rounded toward minus infinity.
            logic signed [SAMPLE_BITS:0] pair_sum;
            assign pair_sum =
                {cell_value_next[WINDOW/2-1][SAMPLE_BITS-1], cell_value_next[WINDOW/2-1]}
                + {cell_value_next[WINDOW/2][SAMPLE_BITS-1], cell_value_next[WINDOW/2]};
            assign median_next = pair_sum[SAMPLE_BITS:1];
        end
        else
        begin : g_odd
            assign median_next = cell_value_next[WINDOW/2];
        end
    endgenerate

endmodule

`default_nettype wire

[rtl/core/imu_nine_axis_running_median_top.sv]
// ----------------------------------------------------------------------------
// imu_nine_axis_running_median_top
// Nine-axis running median filter over a sliding window of raw IMU samples.
//
//   Channel   Direction  Beat contents
//   sample    in         accel, gyro and mag x/y/z raw counts, signed
//   median    out        windowed median of each of the nine channels
//
// One sample beat is taken per clock cycle unless median stalls; its medians
// appear in the output register on the next cycle, and throughput is one
// beat per cycle. Each channel keeps its window as a sorted row of WINDOW
// cells; the whole row updates in the accepting cycle, which sets that rate.
// Reset clears every window entry to zero and the output register to empty.
// A stall on median holds the output beat and drops sample.ready only while
// the output register is full and not being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_nine_axis_running_median_top
    import imu9rm_pkg::*;
#(
    parameter int WINDOW      = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    imu9rm_sample_if.sink   sample,
    imu9rm_median_if.source median
);

`include "imu_nine_axis_running_median_top_macros.svh"

    logic                          accept;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] channel_sample [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] channel_median [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] median_reg     [CHANNELS];

    // The output register frees up in the same cycle it is drained, so a
    // steady stream flows at one beat per clock while median.ready stays high.
    assign sample.ready = !out_valid_reg || median.ready;
    assign accept       = sample.valid && sample.ready;

    // Channel order follows the beat: accelerometer, gyroscope, magnetometer.
    assign channel_sample[0] = sample.accel_x;
    assign channel_sample[1] = sample.accel_y;
    assign channel_sample[2] = sample.accel_z;
    assign channel_sample[3] = sample.gyro_x;
    assign channel_sample[4] = sample.gyro_y;
    assign channel_sample[5] = sample.gyro_z;
    assign channel_sample[6] = sample.mag_x;
    assign channel_sample[7] = sample.mag_y;
    assign channel_sample[8] = sample.mag_z;

    // Each lane removes its oldest entry, inserts the new sample in sorted
    // order and reports the median of the updated window.
    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_lane
            imu9rm_lane #(
                .WINDOW      (WINDOW),
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (accept),
                .sample      (channel_sample[c]),
                .median_next (channel_median[c])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            out_valid_reg <= sample.valid;
        end
    end

    // The result payload is only looked at while out_valid_reg is set.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            median_reg <= channel_median;
        end
    end

    assign median.valid          = out_valid_reg;
    assign median.median_accel_x = median_reg[0];
    assign median.median_accel_y = median_reg[1];
    assign median.median_accel_z = median_reg[2];
    assign median.median_gyro_x  = median_reg[3];
    assign median.median_gyro_y  = median_reg[4];
    assign median.median_gyro_z  = median_reg[5];
    assign median.median_mag_x   = median_reg[6];
    assign median.median_mag_y   = median_reg[7];
    assign median.median_mag_z   = median_reg[8];

    // An empty output register must never hold off the input side.
    `IMU9RM_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, sample.ready, "input stalled while output empty")

    // Every accepted sample produces a result beat in the following cycle.
    `IMU9RM_ASSERT_NEXT(a_accept_gives_result, accept, median.valid, "accepted beat produced no result")

    // A full, stalled output register must block new samples.
    `IMU9RM_ASSERT_NOW(a_backpressure, median.valid && !median.ready, !sample.ready, "sample accepted over a stalled result")

endmodule

`default_nettype wire

[tb/imu9rm_median_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu9rm_median_checker
// Watches the sample and median channels of the running median filter. It
// keeps its own four-deep window per axis, works out the nine medians of
// every accepted sample beat and compares them with the median beats in order.
// ----------------------------------------------------------------------------

module imu9rm_median_checker (
    input  logic        clk,
    input  logic        rst_n,
    imu9rm_sample_if    sample,
    imu9rm_median_if    median,
    output int unsigned fail_count,
    output int unsigned pending_count,
    output int unsigned median_count
);
    localparam int AXES         = imu9rm_pkg::CHANNELS;
    localparam int SLOTS        = 4;
    localparam int REPORT_LIMIT = 10;

    // Index 0 is accel_x, index 8 is mag_z.
    typedef logic [AXES-1:0][15:0] axis_vec_t;

    string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z",
                                "gyro_x", "gyro_y", "gyro_z",
                                "mag_x", "mag_y", "mag_z"};

    logic signed [15:0] history [AXES][SLOTS];
    logic [1:0]         next_slot;
    axis_vec_t          expected_medians [$];
    axis_vec_t          taken;
    axis_vec_t          predicted;
    axis_vec_t          given;
    axis_vec_t          wanted;

    // Sorts the four window entries and returns the floor of the mean of the
    // two middle ones; bits 16:1 of the 17-bit sum are exactly that floor.
    function automatic logic [15:0] middle_mean(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c,
                                                input logic signed [15:0] d);
        logic signed [15:0] v [4];
        logic signed [15:0] t;
        logic signed [16:0] pair_sum;
        int i;
        int j;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        for (i = 1; i < 4; i++) begin
            for (j = i; j > 0; j--) begin
                if (v[j-1] > v[j]) begin
                    t      = v[j];
                    v[j]   = v[j-1];
                    v[j-1] = t;
                end
            end
        end
        pair_sum = v[1] + v[2];
        return pair_sum[16:1];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int ax = 0; ax < AXES; ax++) begin
                for (int s = 0; s < SLOTS; s++) begin
                    history[ax][s] = '0;
                end
            end
            next_slot = '0;
            expected_medians.delete();
            fail_count    = 0;
            pending_count = 0;
            median_count  = 0;
        end
        else begin
            if (sample.valid && sample.ready) begin
                taken = {sample.mag_z, sample.mag_y, sample.mag_x,
                         sample.gyro_z, sample.gyro_y, sample.gyro_x,
                         sample.accel_z, sample.accel_y, sample.accel_x};
                for (int ax = 0; ax < AXES; ax++) begin
                    history[ax][next_slot] = taken[ax];
                end
                next_slot = next_slot + 2'd1;
                for (int ax = 0; ax < AXES; ax++) begin
                    predicted[ax] = middle_mean(history[ax][0], history[ax][1],
                                                history[ax][2], history[ax][3]);
                end
                expected_medians.push_back(predicted);
            end
            if (median.valid && median.ready) begin
                given = {median.median_mag_z, median.median_mag_y, median.median_mag_x,
                         median.median_gyro_z, median.median_gyro_y, median.median_gyro_x,
                         median.median_accel_z, median.median_accel_y,
                         median.median_accel_x};
                if (expected_medians.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("Median beat %0d arrived with no sample outstanding",
                                 median_count);
                    end
                    fail_count++;
                end
                else begin
                    wanted = expected_medians.pop_front();
                    for (int ax = 0; ax < AXES; ax++) begin
                        if (given[ax] !== wanted[ax]) begin
                            if (fail_count < REPORT_LIMIT) begin
                                $display("Median beat %0d, %s: expected %0d, got %0d",
                                         median_count, axis_name[ax],
                                         $signed(wanted[ax]), $signed(given[ax]));
                            end
                            fail_count++;
                        end
                    end
                end
                median_count++;
            end
            pending_count = expected_medians.size();
        end
    end

endmodule

[tb/imu_nine_axis_running_median_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_nine_axis_running_median_top_test
// Drives nine-axis sample beats into the running median filter and drains the
// median beats with random back-pressure. A short directed run covers the
// field extremes, the partly filled window, ring wrap, ties and the rounding
// of the even-window mean; a long random run follows. The checker beside the
// block predicts and compares every median beat and reports a failure count.
// ----------------------------------------------------------------------------

module imu_nine_axis_running_median_top_test;

    localparam int RANDOM_SAMPLES = 830;
    localparam int HOLD_CYCLES    = 240;
    localparam int HOLD_BURST     = 40;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int DIRECTED_COUNT = 20;

    // The receiver switches between these styles of accepting median beats.
    typedef enum logic [1:0] {
        DRAIN_OPEN,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_TOGGLE
    } drain_style_t;

    // Index 0 is accel_x, index 8 is mag_z.
    typedef logic [8:0][15:0] sample_vec_t;

    // Directed base values: a zero first so the window starts partly filled
    // with its reset zeros, then the extremes back to back so that the ring
    // wraps with full-scale values in it, then small values around zero for
    // the rounding of the middle-pair mean, a run of equal values for ties,
    // and alternating bit patterns.
    localparam logic [15:0] DIRECTED_BASE [DIRECTED_COUNT] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
        16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0003,
        16'hFFFD, 16'h0005, 16'h0005, 16'h0005, 16'h0005,
        16'h5555, 16'hAAAA, 16'h0064, 16'hFF9C, 16'h0007
    };

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic hold_token = 1'b0;

    int unsigned samples_sent  = 0;
    int unsigned directed_sent = 0;
    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned median_count;

    imu9rm_sample_if #(.SAMPLE_BITS(16)) sample ();
    imu9rm_median_if #(.SAMPLE_BITS(16)) median ();

    imu_nine_axis_running_median_top #(
        .WINDOW      (4),
        .SAMPLE_BITS (16)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .median (median)
    );

    imu9rm_median_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample),
        .median        (median),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .median_count  (median_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // On some beats every odd axis gets the complement of the base value, so
    // the axes do not all see the same sequence and the sign bit flips.
    function automatic sample_vec_t directed_sample(input int unsigned k);
        sample_vec_t v;
        for (int ax = 0; ax < 9; ax++) begin
            if ((k % 3) == 1 && (ax % 2) == 1) begin
                v[ax] = ~DIRECTED_BASE[k];
            end
            else begin
                v[ax] = DIRECTED_BASE[k];
            end
        end
        return v;
    endfunction

    // Half of the values are uniform over the whole range. The rest sit close
    // to zero, where ties and odd middle-pair sums are frequent, or next to
    // either end of the range.
    function automatic logic [15:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick < 4) begin
            return 16'($urandom);
        end
        else if (pick < 6) begin
            return 16'($urandom_range(0, 8) - 4);
        end
        else if (pick == 6) begin
            return 16'h7FFF - 16'($urandom_range(0, 3));
        end
        else begin
            return 16'h8000 + 16'($urandom_range(0, 3));
        end
    endfunction

    function automatic sample_vec_t random_sample();
        sample_vec_t v;
        for (int ax = 0; ax < 9; ax++) begin
            v[ax] = random_value();
        end
        return v;
    endfunction

    // Puts one beat on the sample channel. It is entered just after a rising
    // edge and returns on the edge at which the beat is taken, so a following
    // call keeps valid high without lowering it in between.
    task automatic offer_sample(input sample_vec_t v);
        sample.valid   <= 1'b1;
        sample.accel_x <= v[0];
        sample.accel_y <= v[1];
        sample.accel_z <= v[2];
        sample.gyro_x  <= v[3];
        sample.gyro_y  <= v[4];
        sample.gyro_z  <= v[5];
        sample.mag_x   <= v[6];
        sample.mag_y   <= v[7];
        sample.mag_z   <= v[8];
        @(posedge clk);
        while (!sample.ready) begin
            @(posedge clk);
        end
        samples_sent++;
    endtask

    task automatic idle_for(input int unsigned cycles);
        sample.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender: directed beats, then random bursts of random length with random
    // gaps. About a third of the bursts run straight into the next one, which
    // gives long stretches with no idling. Once, the receiver is asked to hold
    // off while a long burst keeps offering beats, so the output register
    // fills up and the block has to drop sample.ready.
    initial
    begin : sample_feed
        int unsigned k;
        int unsigned burst;
        bit          held;
        held           = 1'b0;
        sample.valid   <= 1'b0;
        sample.accel_x <= '0;
        sample.accel_y <= '0;
        sample.accel_z <= '0;
        sample.gyro_x  <= '0;
        sample.gyro_y  <= '0;
        sample.gyro_z  <= '0;
        sample.mag_x   <= '0;
        sample.mag_y   <= '0;
        sample.mag_z   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_COUNT; k++) begin
            offer_sample(directed_sample(k));
            if ((k % 4) == 3) begin
                idle_for($urandom_range(1, 3));
            end
        end
        directed_sent = samples_sent;

        while (samples_sent < directed_sent + RANDOM_SAMPLES) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst; k++) begin
                offer_sample(random_sample());
            end
            if (!held && samples_sent >= directed_sent + 300) begin
                held = 1'b1;
                hold_token <= ~hold_token;
                for (k = 0; k < HOLD_BURST; k++) begin
                    offer_sample(random_sample());
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_for($urandom_range(1, 6));
            end
        end
        sample.valid <= 1'b0;

        // The checker updates its counts at the rising edge, so they are read
        // at the falling edge. The watchdog covers a block that never drains.
        @(negedge clk);
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d sample beats (%0d directed) with a %0d-cycle output hold-off;",
                 samples_sent, directed_sent, HOLD_CYCLES);
        $display("compared %0d median beats, %0d mismatches.", median_count, fail_count);
        if (fail_count == 0) begin
            $display("PASS imu_nine_axis_running_median_top");
        end
        else begin
            $display("FAIL imu_nine_axis_running_median_top");
        end
        $finish;
    end

    // Receiver: changes its style after each segment of random length. A toggle of
    // hold_token from the sender starts the long hold-off, counted here.
    initial
    begin : median_drain
        drain_style_t style;
        int unsigned  segment_left;
        int unsigned  hold_left;
        logic         hold_seen;
        style        = DRAIN_OPEN;
        segment_left = 0;
        hold_left    = 0;
        hold_seen    = 1'b0;
        median.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (segment_left == 0) begin
                style        = drain_style_t'($urandom_range(0, 3));
                segment_left = $urandom_range(16, 96);
            end
            segment_left--;
            if (hold_left != 0) begin
                hold_left--;
                median.ready <= 1'b0;
            end
            else begin
                case (style)
                    DRAIN_OPEN:   median.ready <= 1'b1;
                    DRAIN_COIN:   median.ready <= 1'($urandom_range(0, 1));
                    DRAIN_SPARSE: median.ready <= ($urandom_range(0, 3) == 0);
                    default:      median.ready <= ~median.ready;
                endcase
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too
    // long. The longest correct quiet spell is the receiver hold-off.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((sample.valid && sample.ready) || (median.valid && median.ready)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
        end
        $display("Timeout: no beat accepted for %0d cycles.", IDLE_LIMIT);
        $display("FAIL imu_nine_axis_running_median_top");
        $finish;
    end

endmodule
